// ===== hw/rtl/cls_pkg.sv =====
// ----------------------------------------------------------------------------
// cls_pkg: shared types and constants of the processor load selector.
// Holds field widths, the mode codes, the controller states, the command and
// status bundles between controller and datapath, and saturating counters.
// ----------------------------------------------------------------------------
`default_nettype none

package cls_pkg;

  // Field widths of the words on the stream ports.
  localparam int MODE_W    = 3;
  localparam int CPU_IDX_W = 6;
  localparam int TICK_W    = 24;
  localparam int LOAD_W    = 7;
  localparam int CNT_W     = 7;
  localparam int GEN_W     = 16;
  localparam int CFG_W     = 7;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;

  // Load arithmetic: numerator busy*100, denominator busy+idle+1.
  localparam int NUM_W = TICK_W + LOAD_W;
  localparam int DEN_W = TICK_W + 1;
  localparam int DIV_SHIFT = LOAD_W - 1;
  localparam int DIV_CNT_W = 3;
  localparam logic [LOAD_W-1:0] LOAD_SCALE = 7'd100;

  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET_ONLINE = 3'd0,
    MODE_UPDATE_LOAD = 3'd1,
    MODE_QUERY = 3'd2,
    MODE_SELECT = 3'd3,
    MODE_BARRIER = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DIV,
    ST_READ,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic scan_init;
    logic mul;
    logic div_step;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  index_ok;
    logic  div_last;
    logic  scan_done;
  } sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v < CNT_MAX) ? v + CNT_W'(1) : CNT_MAX;
  endfunction

  function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
    return (v != '0) ? v - CNT_W'(1) : '0;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cls_ram.sv =====
// ----------------------------------------------------------------------------
// cls_ram: generic single-write, single-read RAM.
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/cls_dp.sv =====
// ----------------------------------------------------------------------------
// cls_dp: datapath of the processor load selector.
// Holds the input word, the online flags, the load table, the counters, a
// restoring divider, the selection scan and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_dp #(
  parameter int MAX_CPUS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire cls_pkg::cmd_t                    cmd,
  output cls_pkg::sts_t                         sts,
  input  wire logic [cls_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic [cls_pkg::MODE_W-1:0]       in_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [cls_pkg::CFG_W-1:0]        cfg_wdata,
  output logic      [cls_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int AW = $clog2(MAX_CPUS);
  localparam int CW = $clog2(MAX_CPUS + 1);

  // Input word.
  cls_pkg::mode_t                   mode_r;
  logic [cls_pkg::CPU_IDX_W-1:0]    idx_r;
  logic                             flag_r;
  logic [cls_pkg::TICK_W-1:0]       busy_r;
  logic [cls_pkg::TICK_W-1:0]       idle_r;

  // Block state.
  logic [MAX_CPUS-1:0]              online_r;
  logic [MAX_CPUS-1:0]              load_vld_r;
  logic [cls_pkg::CNT_W-1:0]        online_cnt_r;
  logic [cls_pkg::CNT_W-1:0]        active_cnt_r;
  logic [cls_pkg::CNT_W-1:0]        arr_cnt_r;
  logic [cls_pkg::GEN_W-1:0]        gen_r;
  logic [cls_pkg::CFG_W-1:0]        cfg_n_r;

  // Divider.
  logic [cls_pkg::NUM_W-1:0]        rem_r;
  logic [cls_pkg::NUM_W-1:0]        den_sh_r;
  logic [cls_pkg::LOAD_W-1:0]       quo_r;
  logic [cls_pkg::DIV_CNT_W-1:0]    div_cnt_r;
  logic [cls_pkg::NUM_W:0]          div_diff;

  // Scan.
  logic [CW-1:0]                    scan_idx_r;
  logic [CW-1:0]                    scan_n;
  logic                             scan_issue;
  logic                             cmp_act_r;
  logic [AW-1:0]                    cmp_idx_r;
  logic                             found_r;
  logic [AW-1:0]                    best_r;
  logic [cls_pkg::LOAD_W-1:0]       best_load_r;

  // Load table read path.
  logic [AW-1:0]                    aidx;
  logic [AW-1:0]                    ram_raddr;
  logic [cls_pkg::LOAD_W-1:0]       ram_rdata;
  logic                             rvld_r;
  logic [cls_pkg::LOAD_W-1:0]       ent_load;

  // Commit values.
  logic                             ok;
  logic                             flag_chg;
  logic [cls_pkg::CNT_W-1:0]        online_cnt_nxt;
  logic [cls_pkg::CNT_W-1:0]        active_cnt_nxt;
  logic [cls_pkg::CNT_W-1:0]        arr_inc;
  logic                             rel;
  logic [cls_pkg::CNT_W-1:0]        arr_cnt_nxt;
  logic [cls_pkg::GEN_W-1:0]        gen_nxt;
  logic                             r_online;
  logic [cls_pkg::LOAD_W-1:0]       r_load;
  logic [cls_pkg::CPU_IDX_W-1:0]    r_sel;
  logic [cls_pkg::OUT_DATA_W-1:0]   out_data_r;
  logic                             ram_we;

  assign ok   = ({1'b0, idx_r} < (cls_pkg::CPU_IDX_W + 1)'(MAX_CPUS));
  assign aidx = idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= cls_pkg::mode_t'(in_tuser);
      idx_r  <= in_tdata[5:0];
      flag_r <= in_tdata[6];
      busy_r <= in_tdata[30:7];
      idle_r <= in_tdata[54:31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_n_r <= cls_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      cfg_n_r <= cfg_wdata;
    end
  end

  // Restoring division: the quotient is below 100, so seven steps suffice.
  assign div_diff = {1'b0, rem_r} - {1'b0, den_sh_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem_r     <= cls_pkg::NUM_W'(busy_r) * cls_pkg::NUM_W'(cls_pkg::LOAD_SCALE);
      den_sh_r  <= {cls_pkg::DEN_W'(busy_r) + cls_pkg::DEN_W'(idle_r) + cls_pkg::DEN_W'(1),
                    cls_pkg::DIV_SHIFT'(0)};
      quo_r     <= '0;
      div_cnt_r <= cls_pkg::DIV_CNT_W'(cls_pkg::DIV_SHIFT);
    end else if (cmd.div_step) begin
      if (!div_diff[cls_pkg::NUM_W]) begin
        rem_r <= div_diff[cls_pkg::NUM_W-1:0];
      end
      quo_r     <= {quo_r[cls_pkg::LOAD_W-2:0], ~div_diff[cls_pkg::NUM_W]};
      den_sh_r  <= den_sh_r >> 1;
      div_cnt_r <= div_cnt_r - cls_pkg::DIV_CNT_W'(1);
    end
  end

  // Load table: entries never written read as zero through the valid bits.
  assign ram_raddr = (mode_r == cls_pkg::MODE_SELECT) ? scan_idx_r[AW-1:0] : aidx;
  assign ram_we    = cmd.commit && (mode_r == cls_pkg::MODE_UPDATE_LOAD) && ok;

  cls_ram #(
    .WIDTH(cls_pkg::LOAD_W),
    .DEPTH(MAX_CPUS)
  ) u_load_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(aidx),
    .wdata(quo_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    rvld_r <= load_vld_r[ram_raddr];
  end

  assign ent_load = rvld_r ? ram_rdata : '0;

  // Selection scan: one table entry issued and one compared per cycle.
  assign scan_n     = (cfg_n_r >= cls_pkg::CFG_W'(MAX_CPUS)) ? CW'(MAX_CPUS) : cfg_n_r[CW-1:0];
  assign scan_issue = (scan_idx_r < scan_n);

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_idx_r  <= '0;
      cmp_act_r   <= 1'b0;
      found_r     <= 1'b0;
      best_r      <= '0;
      best_load_r <= '0;
    end else if (cmd.scan_step) begin
      if (scan_issue) begin
        scan_idx_r <= scan_idx_r + CW'(1);
      end
      cmp_act_r <= scan_issue;
      cmp_idx_r <= scan_idx_r[AW-1:0];
      if (cmp_act_r && online_r[cmp_idx_r] && (!found_r || ent_load < best_load_r)) begin
        best_r      <= cmp_idx_r;
        best_load_r <= ent_load;
        found_r     <= 1'b1;
      end
    end
  end

  // State updates at commit.
  assign flag_chg = (mode_r == cls_pkg::MODE_SET_ONLINE) && ok && (online_r[aidx] != flag_r);

  always_comb begin
    online_cnt_nxt = online_cnt_r;
    active_cnt_nxt = active_cnt_r;
    if (flag_chg) begin
      if (flag_r) begin
        online_cnt_nxt = cls_pkg::sat_inc(online_cnt_r);
        active_cnt_nxt = cls_pkg::sat_inc(active_cnt_r);
      end else begin
        online_cnt_nxt = cls_pkg::sat_dec(online_cnt_r);
        active_cnt_nxt = cls_pkg::sat_dec(active_cnt_r);
      end
    end
  end

  assign arr_inc     = cls_pkg::sat_inc(arr_cnt_r);
  assign rel         = (mode_r == cls_pkg::MODE_BARRIER) && (arr_inc >= active_cnt_r);
  assign arr_cnt_nxt = (mode_r != cls_pkg::MODE_BARRIER) ? arr_cnt_r :
                       (rel ? '0 : arr_inc);
  assign gen_nxt     = rel ? gen_r + cls_pkg::GEN_W'(1) : gen_r;

  assign r_online = (mode_r == cls_pkg::MODE_QUERY) && ok && online_r[aidx];

  always_comb begin
    r_load = '0;
    if (ok && (mode_r == cls_pkg::MODE_UPDATE_LOAD)) begin
      r_load = quo_r;
    end else if (ok && (mode_r == cls_pkg::MODE_QUERY)) begin
      r_load = ent_load;
    end
  end

  assign r_sel = (mode_r == cls_pkg::MODE_SELECT) ? cls_pkg::CPU_IDX_W'(best_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r     <= MAX_CPUS'(1);
      load_vld_r   <= '0;
      online_cnt_r <= cls_pkg::CNT_W'(1);
      active_cnt_r <= cls_pkg::CNT_W'(1);
      arr_cnt_r    <= '0;
      gen_r        <= '0;
    end else if (cmd.commit) begin
      if (flag_chg) begin
        online_r[aidx] <= flag_r;
      end
      if (ram_we) begin
        load_vld_r[aidx] <= 1'b1;
      end
      online_cnt_r <= online_cnt_nxt;
      active_cnt_r <= active_cnt_nxt;
      arr_cnt_r    <= arr_cnt_nxt;
      gen_r        <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {2'b00, active_cnt_nxt, online_cnt_nxt, gen_nxt, rel,
                     r_sel, r_load, r_online, ok};
    end
  end

  assign out_tdata = out_data_r;

  assign sts.mode      = mode_r;
  assign sts.index_ok  = ok;
  assign sts.div_last  = (div_cnt_r == '0);
  assign sts.scan_done = !scan_issue && !cmp_act_r;

endmodule

`default_nettype wire

// ===== hw/rtl/cls_ctrl.sv =====
// ----------------------------------------------------------------------------
// cls_ctrl: controller of the processor load selector.
// Sequences one word through decode, divide, read or scan and commit, and
// owns the handshake of both stream channels.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire cls_pkg::sts_t sts,
  output cls_pkg::cmd_t      cmd
);

  cls_pkg::state_t state_r;
  cls_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cls_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = cls_pkg::ST_DECODE;
        end
      end
      cls_pkg::ST_DECODE: begin
        unique case (sts.mode)
          cls_pkg::MODE_UPDATE_LOAD: begin
            state_nxt = sts.index_ok ? cls_pkg::ST_MUL : cls_pkg::ST_FINISH;
          end
          cls_pkg::MODE_QUERY:  state_nxt = cls_pkg::ST_READ;
          cls_pkg::MODE_SELECT: state_nxt = cls_pkg::ST_SCAN;
          default:              state_nxt = cls_pkg::ST_FINISH;
        endcase
      end
      cls_pkg::ST_MUL:  state_nxt = cls_pkg::ST_DIV;
      cls_pkg::ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = cls_pkg::ST_FINISH;
        end
      end
      cls_pkg::ST_READ: state_nxt = cls_pkg::ST_FINISH;
      cls_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = cls_pkg::ST_FINISH;
        end
      end
      cls_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = cls_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      cls_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      cls_pkg::ST_DECODE: cmd.scan_init = (sts.mode == cls_pkg::MODE_SELECT);
      cls_pkg::ST_MUL:    cmd.mul = 1'b1;
      cls_pkg::ST_DIV:    cmd.div_step = 1'b1;
      cls_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
      cls_pkg::ST_FINISH: cmd.commit = out_free;
      default:            cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cls_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/cpu_online_load_selector.sv =====
// ----------------------------------------------------------------------------
// cpu_online_load_selector: processor online table, load table and barrier.
// Keeps an online flag and a load percentage per processor, the online and
// active counts, and an arrival barrier with a generation count.
// ----------------------------------------------------------------------------
// Usage. Each input word carries a mode in in_tuser and its operands in
// in_tdata; every word yields exactly one result word on the out_ channel.
// Mode 0 sets a processor online or offline, mode 1 computes and stores a
// load percentage, mode 2 reads a processor's flag and load, mode 3 picks the
// least loaded online processor and mode 4 is one barrier arrival.
// The block works on one word at a time. From acceptance to commit, a word
// passes only through decode in modes 0 and 4, in unused modes and in mode 1
// with an index out of range, through one table read in mode 2, through a
// multiply and seven restoring division steps in mode 1 and through a scan
// of n entries in mode 3, where n is cpus_in_use clamped to MAX_CPUS: the
// scan reads one table entry per cycle. The result word is valid the cycle
// after commit, and in_tready rises in that same cycle, so the next word may
// be accepted in that cycle while the result is still waiting.
// If the receiver stalls, the result stays in the output register and a
// following word finishes its work and then waits until that register frees.
// Synchronous reset marks processor 0 online and all others offline, clears
// the loads, sets both counts to one and cpus_in_use to one. cfg_we writes
// cpus_in_use and is meant to be used only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_online_load_selector #(
  parameter int MAX_CPUS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input words.
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // cpu_index [5:0], online_flag [6], busy_count [30:7], idle_count [54:31],
  // zero pad [55].
  input  wire logic [cls_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode [2:0].
  input  wire logic [cls_pkg::MODE_W-1:0]     in_tuser,
  // Result words.
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // index_ok [0], cpu_online [1], cpu_load [8:2], selected_cpu [14:9],
  // barrier_released [15], barrier_generation [31:16], online_total [38:32],
  // active_total [45:39], zero pad [47:46].
  output logic      [cls_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration: cpus_in_use.
  input  wire logic                           cfg_we,
  input  wire logic [cls_pkg::CFG_W-1:0]      cfg_wdata
);

  cls_pkg::cmd_t cmd;
  cls_pkg::sts_t sts;

  // The controller owns both handshakes and sequences the datapath.
  cls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds all tables, counters, the divider and the result.
  cls_dp #(
    .MAX_CPUS(MAX_CPUS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_tdata(out_tdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/cls_chk.sv =====
// ----------------------------------------------------------------------------
// cls_chk: port checker for the processor load selector.
// Watches the stream ports and flags violations of the block's behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_chk #(
  parameter int MAX_CPUS = 8
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [cls_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // The block works on one word at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while one is in work");

  // A load percentage never reaches 100.
  a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:2] < 7'd100)
    else $error("load out of range");

  // The selected processor always lies inside the table.
  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> {1'b0, out_tdata[14:9]} < 7'(MAX_CPUS))
    else $error("selected processor out of range");

  // No result word right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

endmodule

bind cpu_online_load_selector cls_chk #(
  .MAX_CPUS(MAX_CPUS)
) u_cls_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the processor online/load selector
// A directed table runs first and then random traffic under several scan
// lengths. Each result word is checked field by field against a typed row or
// a shadow model of the online and load tables, the counters and the barrier.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cls_pkg::*;

  // Table size of the instance under test.
  localparam int DUT_CPUS = 8;
  // Highest value that the 6-bit processor index can carry.
  localparam int IDX_TOP = 63;
  // Load is a percentage of busy over all ticks.
  localparam int unsigned LOAD_PERCENT = 100;
  // Mode codes that the block has no operation for.
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
  localparam int N_DIRECTED = 25;
  localparam int N_PHASES = 7;
  localparam int WORDS_PER_PHASE = 215;
  // Longest word is a full scan. Plenty of margin.
  localparam int DRAIN_CYCLES = 40;

  // One result word, unpacked into its fields.
  typedef struct packed {
    logic              index_ok;
    logic              cpu_online;
    logic [LOAD_W-1:0] cpu_load;
    logic [5:0]        selected_cpu;
    logic              released;
    logic [GEN_W-1:0]  generation;
    logic [CNT_W-1:0]  online_total;
    logic [CNT_W-1:0]  active_total;
  } status_word_t;

  // One row of the directed table. When typed is set, exp is the result read
  // straight off the specification; otherwise the shadow model decides.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [5:0]        idx;
    logic              flag;
    logic [TICK_W-1:0] busy;
    logic [TICK_W-1:0] idle;
    logic              typed;
    status_word_t      exp;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  // Shadow copy of the block's state and of the scan length register.
  logic [DUT_CPUS-1:0] sh_online;
  logic [LOAD_W-1:0]   sh_load [DUT_CPUS];
  logic [CNT_W-1:0]    sh_online_cnt;
  logic [CNT_W-1:0]    sh_active_cnt;
  logic [CNT_W-1:0]    sh_arrivals;
  logic [GEN_W-1:0]    sh_generation;
  logic [CFG_W-1:0]    sh_cpus_in_use;

  // Result words still owed by the block, oldest first.
  status_word_t sched_results_q [$];

  int  mismatches = 0;
  // Set for the last phase: the sender and the receiver stop idling.
  bit  quiet = 1'b0;
  int  stall_left = 0;

  status_word_t seen;
  status_word_t want;

  // Directed words. The typed rows follow the state from reset onward: the
  // reset state, out-of-range indexes, extreme tick counts, repeated flags,
  // a barrier round, spare modes, selection with nothing online and an
  // arrival with an active count of zero.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{MODE_QUERY,       6'd0,  1'b0, 24'd0,       24'd0,       1'b1,
      '{1'b1, 1'b1, 7'd0,  6'd0, 1'b0, 16'd0, 7'd1, 7'd1}},
    '{MODE_QUERY,       6'd63, 1'b1, 24'd0,       24'd0,       1'b1,
      '{1'b0, 1'b0, 7'd0,  6'd0, 1'b0, 16'd0, 7'd1, 7'd1}},
    '{MODE_SELECT,      6'd0,  1'b0, 24'd0,       24'd0,       1'b1,
      '{1'b1, 1'b0, 7'd0,  6'd0, 1'b0, 16'd0, 7'd1, 7'd1}},
    '{MODE_BARRIER,     6'd0,  1'b0, 24'd0,       24'd0,       1'b1,
      '{1'b1, 1'b0, 7'd0,  6'd0, 1'b1, 16'd1, 7'd1, 7'd1}},
    '{MODE_UPDATE_LOAD, 6'd7,  1'b0, 24'hFFFFFF,  24'hFFFFFF,  1'b1,
      '{1'b1, 1'b0, 7'd49, 6'd0, 1'b0, 16'd1, 7'd1, 7'd1}},
    '{MODE_UPDATE_LOAD, 6'd6,  1'b0, 24'hFFFFFF,  24'd0,       1'b1,
      '{1'b1, 1'b0, 7'd99, 6'd0, 1'b0, 16'd1, 7'd1, 7'd1}},
    '{MODE_UPDATE_LOAD, 6'd5,  1'b0, 24'd0,       24'hFFFFFF,  1'b1,
      '{1'b1, 1'b0, 7'd0,  6'd0, 1'b0, 16'd1, 7'd1, 7'd1}},
    '{MODE_UPDATE_LOAD, 6'd8,  1'b0, 24'd5,       24'd5,       1'b1,
      '{1'b0, 1'b0, 7'd0,  6'd0, 1'b0, 16'd1, 7'd1, 7'd1}},
    '{MODE_SET_ONLINE,  6'd7,  1'b1, 24'd0,       24'd0,       1'b1,
      '{1'b1, 1'b0, 7'd0,  6'd0, 1'b0, 16'd1, 7'd2, 7'd2}},
    '{MODE_SET_ONLINE,  6'd7,  1'b1, 24'd0,       24'd0,       1'b1,
      '{1'b1, 1'b0, 7'd0,  6'd0, 1'b0, 16'd1, 7'd2, 7'd2}},
    '{MODE_SET_ONLINE,  6'd63, 1'b1, 24'd0,       24'd0,       1'b1,
      '{1'b0, 1'b0, 7'd0,  6'd0, 1'b0, 16'd1, 7'd2, 7'd2}},
    '{MODE_SET_ONLINE,  6'd6,  1'b1, 24'd0,       24'd0,       1'b1,
      '{1'b1, 1'b0, 7'd0,  6'd0, 1'b0, 16'd1, 7'd3, 7'd3}},
    '{MODE_QUERY,       6'd6,  1'b0, 24'd0,       24'd0,       1'b1,
      '{1'b1, 1'b1, 7'd99, 6'd0, 1'b0, 16'd1, 7'd3, 7'd3}},
    '{MODE_BARRIER,     6'd0,  1'b0, 24'd0,       24'd0,       1'b1,
      '{1'b1, 1'b0, 7'd0,  6'd0, 1'b0, 16'd1, 7'd3, 7'd3}},
    '{MODE_BARRIER,     6'd63, 1'b0, 24'd0,       24'd0,       1'b1,
      '{1'b0, 1'b0, 7'd0,  6'd0, 1'b0, 16'd1, 7'd3, 7'd3}},
    '{MODE_BARRIER,     6'd0,  1'b0, 24'd0,       24'd0,       1'b1,
      '{1'b1, 1'b0, 7'd0,  6'd0, 1'b1, 16'd2, 7'd3, 7'd3}},
    '{MODE_SPARE_FIRST, 6'd3,  1'b1, 24'd77,      24'd77,      1'b1,
      '{1'b1, 1'b0, 7'd0,  6'd0, 1'b0, 16'd2, 7'd3, 7'd3}},
    '{MODE_SPARE_LAST,  6'd63, 1'b1, 24'hFFFFFF,  24'hFFFFFF,  1'b1,
      '{1'b0, 1'b0, 7'd0,  6'd0, 1'b0, 16'd2, 7'd3, 7'd3}},
    '{MODE_SET_ONLINE,  6'd0,  1'b0, 24'd0,       24'd0,       1'b1,
      '{1'b1, 1'b0, 7'd0,  6'd0, 1'b0, 16'd2, 7'd2, 7'd2}},
    '{MODE_SET_ONLINE,  6'd6,  1'b0, 24'd0,       24'd0,       1'b1,
      '{1'b1, 1'b0, 7'd0,  6'd0, 1'b0, 16'd2, 7'd1, 7'd1}},
    '{MODE_SET_ONLINE,  6'd7,  1'b0, 24'd0,       24'd0,       1'b1,
      '{1'b1, 1'b0, 7'd0,  6'd0, 1'b0, 16'd2, 7'd0, 7'd0}},
    '{MODE_SELECT,      6'd0,  1'b0, 24'd0,       24'd0,       1'b1,
      '{1'b1, 1'b0, 7'd0,  6'd0, 1'b0, 16'd2, 7'd0, 7'd0}},
    '{MODE_BARRIER,     6'd0,  1'b0, 24'd0,       24'd0,       1'b1,
      '{1'b1, 1'b0, 7'd0,  6'd0, 1'b1, 16'd3, 7'd0, 7'd0}},
    '{MODE_UPDATE_LOAD, 6'd3,  1'b0, 24'h123456,  24'h0F0F0F,  1'b0, '0},
    '{MODE_SET_ONLINE,  6'd3,  1'b1, 24'd0,       24'd0,       1'b0, '0}
  };

  // Scan lengths of the random phases, the extremes among them.
  int unsigned phase_cpus [N_PHASES] = '{8, 0, 64, 127, 3, 1, 8};

  cpu_online_load_selector #(
    .MAX_CPUS (DUT_CPUS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow model: applies one word to the shadow state and returns the
  // result word that the block owes for it.
  task automatic sched_op_outcome(input logic [MODE_W-1:0] mode, input logic [5:0] idx,
                                  input logic flag, input logic [TICK_W-1:0] busy,
                                  input logic [TICK_W-1:0] idle,
                                  output status_word_t res);
    logic        in_range;
    logic [31:0] num;
    logic [31:0] den;
    int unsigned scan_len;
    int unsigned best;
    bit          found;
    in_range = (int'(idx) < DUT_CPUS);
    res = '0;
    res.index_ok = in_range;
    case (mode)
      MODE_SET_ONLINE: begin
        // A flag equal to the stored one leaves the counters alone.
        if (in_range && sh_online[idx] != flag) begin
          sh_online[idx] = flag;
          if (flag) begin
            sh_online_cnt = (sh_online_cnt < CNT_MAX) ? sh_online_cnt + 7'd1 : CNT_MAX;
            sh_active_cnt = (sh_active_cnt < CNT_MAX) ? sh_active_cnt + 7'd1 : CNT_MAX;
          end else begin
            sh_online_cnt = (sh_online_cnt != 0) ? sh_online_cnt - 7'd1 : 7'd0;
            sh_active_cnt = (sh_active_cnt != 0) ? sh_active_cnt - 7'd1 : 7'd0;
          end
        end
      end
      MODE_UPDATE_LOAD: begin
        if (in_range) begin
          num = 32'(busy) * LOAD_PERCENT;
          den = 32'(busy) + 32'(idle) + 32'd1;
          sh_load[idx] = LOAD_W'(num / den);
          res.cpu_load = sh_load[idx];
        end
      end
      MODE_QUERY: begin
        if (in_range) begin
          res.cpu_online = sh_online[idx];
          res.cpu_load = sh_load[idx];
        end
      end
      MODE_SELECT: begin
        // Strict less-than keeps the lowest index on equal loads.
        scan_len = (sh_cpus_in_use < DUT_CPUS) ? sh_cpus_in_use : DUT_CPUS;
        found = 1'b0;
        best = 0;
        for (int i = 0; i < scan_len; i++) begin
          if (sh_online[i] && (!found || sh_load[i] < sh_load[best])) begin
            best = i;
            found = 1'b1;
          end
        end
        res.selected_cpu = 6'(best);
      end
      MODE_BARRIER: begin
        sh_arrivals = (sh_arrivals < CNT_MAX) ? sh_arrivals + 7'd1 : CNT_MAX;
        if (sh_arrivals >= sh_active_cnt) begin
          sh_arrivals = '0;
          sh_generation = sh_generation + 16'd1;
          res.released = 1'b1;
        end
      end
      default: ;
    endcase
    res.generation = sh_generation;
    res.online_total = sh_online_cnt;
    res.active_total = sh_active_cnt;
  endtask

  // Presents one word, holds it until the block takes it, and queues what
  // the block must answer. in_tvalid stays high on return so that a next
  // word can follow back to back.
  task automatic send_sched_op(input logic [MODE_W-1:0] mode, input logic [5:0] idx,
                               input logic flag, input logic [TICK_W-1:0] busy,
                               input logic [TICK_W-1:0] idle, input logic typed,
                               input status_word_t typed_exp);
    status_word_t predicted;
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {1'b0, idle, busy, flag, idx};
    do
      @(posedge clk);
    while (!in_tready);
    sched_op_outcome(mode, idx, flag, busy, idle, predicted);
    sched_results_q.push_back(typed ? typed_exp : predicted);
  endtask

  // Random sender gap ahead of some words.
  task automatic maybe_pause_sender();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Tick counts: the extremes, small values and full random values.
  function automatic logic [TICK_W-1:0] random_ticks();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return TICK_W'($urandom_range(0, 255));
      default: return TICK_W'($urandom());
    endcase
  endfunction

  function automatic void compare_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
    if (exp_val != act_val) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, name, exp_val, act_val);
    end
  endfunction

  // Receiver: out_tready drops in random bursts, never in the quiet last phase.
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker: every accepted result word is matched against the
  // oldest word still owed.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.index_ok     = out_tdata[0];
      seen.cpu_online   = out_tdata[1];
      seen.cpu_load     = out_tdata[8:2];
      seen.selected_cpu = out_tdata[14:9];
      seen.released     = out_tdata[15];
      seen.generation   = out_tdata[31:16];
      seen.online_total = out_tdata[38:32];
      seen.active_total = out_tdata[45:39];
      if (sched_results_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: result word with none expected, expected nothing, actual %h",
                 $time, out_tdata);
      end else begin
        want = sched_results_q.pop_front();
        compare_field("index_ok", want.index_ok, seen.index_ok);
        compare_field("cpu_online", want.cpu_online, seen.cpu_online);
        compare_field("cpu_load", want.cpu_load, seen.cpu_load);
        compare_field("selected_cpu", want.selected_cpu, seen.selected_cpu);
        compare_field("barrier_released", want.released, seen.released);
        compare_field("barrier_generation", want.generation, seen.generation);
        compare_field("online_total", want.online_total, seen.online_total);
        compare_field("active_total", want.active_total, seen.active_total);
      end
    end
  end

  // Stimulus.
  initial begin : stimulus
    logic [MODE_W-1:0] r_mode;
    logic [5:0]        r_idx;
    int unsigned       pick;

    // Shadow state as the block comes out of reset: processor 0 online,
    // loads clear, both counts at one, scan length one.
    sh_online = '0;
    sh_online[0] = 1'b1;
    foreach (sh_load[i]) sh_load[i] = '0;
    sh_online_cnt = 7'd1;
    sh_active_cnt = 7'd1;
    sh_arrivals = '0;
    sh_generation = '0;
    sh_cpus_in_use = 7'd1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (directed_rows[r]) begin
      maybe_pause_sender();
      send_sched_op(directed_rows[r].mode, directed_rows[r].idx, directed_rows[r].flag,
                    directed_rows[r].busy, directed_rows[r].idle, directed_rows[r].typed,
                    directed_rows[r].exp);
    end

    // Random phases. Before each phase the sender waits until every owed
    // result has come back, so the scan length is only changed while the
    // block is idle.
    for (int p = 0; p < N_PHASES; p++) begin
      in_tvalid <= 1'b0;
      while (sched_results_q.size() != 0) @(posedge clk);
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= CFG_W'(phase_cpus[p]);
      @(posedge clk);
      cfg_we <= 1'b0;
      sh_cpus_in_use = CFG_W'(phase_cpus[p]);
      if (p == N_PHASES - 1)
        quiet = 1'b1;

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 20)
          r_mode = MODE_SET_ONLINE;
        else if (pick < 40)
          r_mode = MODE_UPDATE_LOAD;
        else if (pick < 55)
          r_mode = MODE_QUERY;
        else if (pick < 75)
          r_mode = MODE_SELECT;
        else if (pick < 95)
          r_mode = MODE_BARRIER;
        else
          r_mode = MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
        // Mostly valid processors; now and then one past the table.
        if ($urandom_range(0, 9) == 0)
          r_idx = 6'($urandom_range(IDX_TOP, DUT_CPUS));
        else
          r_idx = 6'($urandom_range(DUT_CPUS - 1, 0));
        maybe_pause_sender();
        send_sched_op(r_mode, r_idx, 1'($urandom()), random_ticks(), random_ticks(),
                      1'b0, '0);
      end
    end

    // Drain: wait for every owed word, then a few more cycles so that any
    // stray result word still shows up in the checker.
    in_tvalid <= 1'b0;
    while (sched_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
